// ===== hdl/hpb_pkg.sv =====
package hpb_pkg;

    localparam int BUFFER_DEPTH_DEF  = 32;
    localparam int RATE_SLOTS_DEF    = 256;
    localparam int DEDUP_ENTRIES_DEF = 8;

    localparam logic [9:0] HINT_LIMIT_RST  = 10'd1000;
    localparam logic [3:0] RESET_LIMIT_RST = 4'd8;
    localparam logic [9:0] HINT_CNT_MAX    = 10'd1023;
    localparam logic [3:0] RESET_CNT_MAX   = 4'd15;

    localparam logic [1:0] MODE_OFFER  = 2'd0;
    localparam logic [1:0] MODE_FLUSH  = 2'd1;
    localparam logic [1:0] MODE_FORGET = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] EV_RESET = 2'd3;

    localparam logic REG_HINT_LIMIT  = 1'b0;
    localparam logic REG_RESET_LIMIT = 1'b1;

    typedef enum logic [3:0] {
        ST_ACCEPTED  = 4'd0,
        ST_SHORT     = 4'd1,
        ST_NO_SIBS   = 4'd2,
        ST_INVALID   = 4'd3,
        ST_RESET_RT  = 4'd4,
        ST_DUPLICATE = 4'd5,
        ST_RATE      = 4'd6,
        ST_FULL      = 4'd7,
        ST_EMPTY     = 4'd8,
        ST_FORGOTTEN = 4'd9
    } status_t;

    typedef struct packed {
        logic [30:0] owner;
        logic [31:0] window;
        logic [9:0]  hint_count;
        logic [3:0]  reset_count;
    } rate_slot_t;

    typedef struct packed {
        logic [15:0] volume_id;
        logic [31:0] node_id;
        logic [30:0] source_id;
        logic [1:0]  event_code;
    } batch_entry_t;

endpackage

// ===== hdl/hint_policer_priority_batcher.sv =====
// Filtered requests, forget, empty flush and the unused mode answer in the cycle after
// acceptance. An offer reads its rate slot (S_RD), is checked in S_RATE and appended in
// S_APPEND, after S_MUL and S_MOD when RATE_SLOTS is not a power of two; a reset first
// scans the dedup entries (S_DEDUP) and, once appended, flushes. A flush reads each entry
// once per event class (S_FL_RD, S_FL_CHK), ending at the last entry. One request is taken
// at a time (busy); the receiver cannot stall. Reset clears the rate table, one slot per cycle.
module hint_policer_priority_batcher #(
    parameter int BUFFER_DEPTH  = hpb_pkg::BUFFER_DEPTH_DEF,
    parameter int RATE_SLOTS    = hpb_pkg::RATE_SLOTS_DEF,
    parameter int DEDUP_ENTRIES = hpb_pkg::DEDUP_ENTRIES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        wr_en,
    input  logic        wr_index,
    input  logic [9:0]  wr_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [30:0] source_id,
    input  logic [31:0] now_seconds,
    input  logic [7:0]  event_code,
    input  logic [15:0] volume_id,
    input  logic [31:0] node_id,
    input  logic        payload_ok,
    input  logic        siblings_present,
    output logic        done,
    output logic        kind,
    output logic [3:0]  status,
    output logic [15:0] out_volume_id,
    output logic [31:0] out_node_id,
    output logic [1:0]  out_event,
    output logic [30:0] out_source_id,
    output logic        last
);

    localparam int RAW = (RATE_SLOTS > 1) ? $clog2(RATE_SLOTS) : 1;
    localparam int RL  = $clog2(RATE_SLOTS);
    localparam int QSH = 31 + RL;
    localparam bit FAST_SLOT = (RATE_SLOTS > 1) && ((RATE_SLOTS & (RATE_SLOTS - 1)) == 0);
    localparam logic [63:0] RECIP_FULL = ((64'd1 << QSH) + 64'(RATE_SLOTS) - 64'd1)
                                         / 64'(RATE_SLOTS);
    localparam logic [31:0] SLOT_RECIP = RECIP_FULL[31:0];
    localparam logic [30:0] SLOTS_W    = 31'(RATE_SLOTS);
    localparam int BAW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam int FW  = $clog2(BUFFER_DEPTH + 1);
    localparam int DW  = (DEDUP_ENTRIES > 1) ? $clog2(DEDUP_ENTRIES) : 1;
    localparam logic [FW-1:0] FILL_FULL = FW'(BUFFER_DEPTH);
    localparam logic [RAW-1:0] SLOT_LAST = RAW'(RATE_SLOTS - 1);
    localparam logic [DW-1:0] DEDUP_LAST = DW'(DEDUP_ENTRIES - 1);

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_MUL, S_MOD, S_RD, S_RATE, S_DEDUP, S_APPEND, S_FL_RD, S_FL_CHK
    } state_t;

    state_t state_reg;
    logic [9:0] hint_limit_reg;
    logic [3:0] reset_limit_reg;

    logic [30:0] src_reg;
    logic [31:0] now_reg;
    logic [1:0]  ev_reg;
    logic [15:0] vol_reg;
    logic [31:0] node_reg;

    logic [RAW-1:0] slot_reg;
    logic [62:0]    prod_reg;

    logic [FW-1:0]  fill_reg;
    logic [FW-1:0]  emitted_reg;
    logic [BAW-1:0] fl_idx_reg;
    logic [1:0]     pass_reg;

    logic [31:0] dedup_tag_reg  [DEDUP_ENTRIES];
    logic [31:0] dedup_time_reg [DEDUP_ENTRIES];
    logic [DW-1:0] scan_reg;
    logic [DW-1:0] oldest_reg;

    logic        done_reg, kind_reg, last_reg;
    hpb_pkg::status_t status_reg;
    hpb_pkg::batch_entry_t out_entry_reg;

    hpb_pkg::rate_slot_t rate_mem [RATE_SLOTS];
    hpb_pkg::rate_slot_t rate_q;
    logic                rate_we;
    logic [RAW-1:0]      rate_waddr;
    hpb_pkg::rate_slot_t rate_wdata;

    hpb_pkg::batch_entry_t batch_mem [BUFFER_DEPTH];
    hpb_pkg::batch_entry_t batch_q;
    logic                  batch_we;
    logic [BAW-1:0]        batch_waddr;
    logic [FW-1:0]         append_pos;

    logic        slot_fresh;
    logic [9:0]  hint_cnt_next;
    logic [3:0]  reset_cnt_next;
    logic [30:0] quot;
    logic [30:0] slot_rem;
    logic        reset_hint;

    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign kind          = kind_reg;
    assign status        = status_reg;
    assign last          = last_reg;
    assign out_volume_id = out_entry_reg.volume_id;
    assign out_node_id   = out_entry_reg.node_id;
    assign out_event     = out_entry_reg.event_code;
    assign out_source_id = out_entry_reg.source_id;
    assign reset_hint    = (ev_reg == hpb_pkg::EV_RESET);

    always_comb
    begin
        slot_fresh = (rate_q.owner != src_reg) || (rate_q.window != now_reg);
        hint_cnt_next  = slot_fresh ? 10'd0 : rate_q.hint_count;
        reset_cnt_next = slot_fresh ? 4'd0 : rate_q.reset_count;
        if (reset_hint)
        begin
            if (reset_cnt_next != hpb_pkg::RESET_CNT_MAX)
            begin
                reset_cnt_next = reset_cnt_next + 4'd1;
            end
        end
        else if (hint_cnt_next != hpb_pkg::HINT_CNT_MAX)
        begin
            hint_cnt_next = hint_cnt_next + 10'd1;
        end
        quot     = 31'(prod_reg >> QSH);
        slot_rem = src_reg - quot * SLOTS_W;
    end

    always_comb
    begin
        rate_we    = 1'b0;
        rate_waddr = slot_reg;
        rate_wdata = '{owner: src_reg, window: now_reg,
                       hint_count: hint_cnt_next, reset_count: reset_cnt_next};
        if (state_reg == S_CLEAR)
        begin
            rate_we    = 1'b1;
            rate_wdata = '0;
        end
        else if (state_reg == S_RATE)
        begin
            rate_we = 1'b1;
        end
        append_pos  = (fill_reg >= FILL_FULL) ? FILL_FULL - FW'(1) : fill_reg;
        batch_waddr = append_pos[BAW-1:0];
        batch_we    = (state_reg == S_APPEND) && (reset_hint || (fill_reg < FILL_FULL));
    end

    always_ff @(posedge clk)
    begin
        if (rate_we)
        begin
            rate_mem[rate_waddr] <= rate_wdata;
        end
        rate_q <= rate_mem[slot_reg];
        if (batch_we)
        begin
            batch_mem[batch_waddr] <= '{volume_id: vol_reg, node_id: node_reg,
                                        source_id: src_reg, event_code: ev_reg};
        end
        batch_q <= batch_mem[fl_idx_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_CLEAR;
            hint_limit_reg  <= hpb_pkg::HINT_LIMIT_RST;
            reset_limit_reg <= hpb_pkg::RESET_LIMIT_RST;
            fill_reg        <= '0;
            slot_reg        <= '0;
            done_reg        <= 1'b0;
            kind_reg        <= 1'b0;
            last_reg        <= 1'b0;
            status_reg      <= hpb_pkg::ST_ACCEPTED;
            out_entry_reg   <= '0;
            for (int i = 0; i < DEDUP_ENTRIES; i++)
            begin
                dedup_tag_reg[i]  <= '0;
                dedup_time_reg[i] <= '0;
            end
        end
        else
        begin
            done_reg <= 1'b0;
            if (wr_en)
            begin
                if (wr_index == hpb_pkg::REG_HINT_LIMIT)
                begin
                    hint_limit_reg <= wr_data;
                end
                else
                begin
                    reset_limit_reg <= wr_data[3:0];
                end
            end
            unique case (state_reg)
                S_CLEAR:
                begin
                    slot_reg <= slot_reg + RAW'(1);
                    if (slot_reg == SLOT_LAST)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (start)
                    begin
                        src_reg  <= source_id;
                        now_reg  <= now_seconds;
                        ev_reg   <= event_code[1:0];
                        vol_reg  <= volume_id;
                        node_reg <= node_id;
                        kind_reg      <= 1'b0;
                        last_reg      <= 1'b1;
                        out_entry_reg <= '0;
                        unique case (mode)
                            hpb_pkg::MODE_FLUSH:
                            begin
                                if (fill_reg == '0)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= hpb_pkg::ST_EMPTY;
                                end
                                else
                                begin
                                    fl_idx_reg  <= '0;
                                    pass_reg    <= '0;
                                    emitted_reg <= '0;
                                    state_reg   <= S_FL_RD;
                                end
                            end
                            hpb_pkg::MODE_FORGET:
                            begin
                                for (int i = 0; i < DEDUP_ENTRIES; i++)
                                begin
                                    if (dedup_tag_reg[i] == node_id)
                                    begin
                                        dedup_tag_reg[i]  <= '0;
                                        dedup_time_reg[i] <= '0;
                                    end
                                end
                                done_reg   <= 1'b1;
                                status_reg <= hpb_pkg::ST_FORGOTTEN;
                            end
                            hpb_pkg::MODE_UNUSED:
                            begin
                                done_reg   <= 1'b1;
                                status_reg <= hpb_pkg::ST_INVALID;
                            end
                            default:
                            begin
                                priority if (!payload_ok)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= hpb_pkg::ST_SHORT;
                                end
                                else if (!siblings_present)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= hpb_pkg::ST_NO_SIBS;
                                end
                                else if (event_code > 8'd3)
                                begin
                                    done_reg   <= 1'b1;
                                    status_reg <= hpb_pkg::ST_INVALID;
                                end
                                else if (FAST_SLOT)
                                begin
                                    slot_reg  <= source_id[RAW-1:0];
                                    state_reg <= S_RD;
                                end
                                else
                                begin
                                    state_reg <= S_MUL;
                                end
                            end
                        endcase
                    end
                end
                S_MUL:
                begin
                    prod_reg  <= src_reg * SLOT_RECIP;
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    slot_reg  <= slot_rem[RAW-1:0];
                    state_reg <= S_RD;
                end
                S_RD:
                begin
                    state_reg <= S_RATE;
                end
                S_RATE:
                begin
                    if (reset_hint)
                    begin
                        if (reset_cnt_next > reset_limit_reg)
                        begin
                            done_reg   <= 1'b1;
                            status_reg <= hpb_pkg::ST_RESET_RT;
                            state_reg  <= S_IDLE;
                        end
                        else
                        begin
                            scan_reg   <= '0;
                            oldest_reg <= '0;
                            state_reg  <= S_DEDUP;
                        end
                    end
                    else if (hint_cnt_next > hint_limit_reg)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= hpb_pkg::ST_RATE;
                        state_reg  <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_APPEND;
                    end
                end
                S_DEDUP:
                begin
                    if (dedup_tag_reg[scan_reg] == node_reg
                        && dedup_time_reg[scan_reg] == now_reg)
                    begin
                        done_reg   <= 1'b1;
                        status_reg <= hpb_pkg::ST_DUPLICATE;
                        state_reg  <= S_IDLE;
                    end
                    else if (scan_reg == DEDUP_LAST)
                    begin
                        if (dedup_time_reg[scan_reg] < dedup_time_reg[oldest_reg])
                        begin
                            dedup_tag_reg[scan_reg]  <= node_reg;
                            dedup_time_reg[scan_reg] <= now_reg;
                        end
                        else
                        begin
                            dedup_tag_reg[oldest_reg]  <= node_reg;
                            dedup_time_reg[oldest_reg] <= now_reg;
                        end
                        state_reg <= S_APPEND;
                    end
                    else
                    begin
                        if (dedup_time_reg[scan_reg] < dedup_time_reg[oldest_reg])
                        begin
                            oldest_reg <= scan_reg;
                        end
                        scan_reg <= scan_reg + DW'(1);
                    end
                end
                S_APPEND:
                begin
                    done_reg  <= 1'b1;
                    state_reg <= S_IDLE;
                    if (!reset_hint && fill_reg >= FILL_FULL)
                    begin
                        status_reg <= hpb_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_reg <= hpb_pkg::ST_ACCEPTED;
                        fill_reg   <= append_pos + FW'(1);
                        if (reset_hint)
                        begin
                            last_reg    <= 1'b0;
                            fl_idx_reg  <= '0;
                            pass_reg    <= '0;
                            emitted_reg <= '0;
                            state_reg   <= S_FL_RD;
                        end
                    end
                end
                S_FL_RD:
                begin
                    state_reg <= S_FL_CHK;
                end
                S_FL_CHK:
                begin
                    state_reg <= S_FL_RD;
                    if (batch_q.event_code == pass_reg - 2'd1)
                    begin
                        done_reg      <= 1'b1;
                        kind_reg      <= 1'b1;
                        status_reg    <= hpb_pkg::ST_ACCEPTED;
                        out_entry_reg <= batch_q;
                        emitted_reg   <= emitted_reg + FW'(1);
                        last_reg      <= (emitted_reg + FW'(1) == fill_reg);
                        if (emitted_reg + FW'(1) == fill_reg)
                        begin
                            fill_reg  <= '0;
                            state_reg <= S_IDLE;
                        end
                    end
                    if (FW'(fl_idx_reg) + FW'(1) == fill_reg)
                    begin
                        fl_idx_reg <= '0;
                        pass_reg   <= pass_reg + 2'd1;
                    end
                    else
                    begin
                        fl_idx_reg <= fl_idx_reg + BAW'(1);
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_reject_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && !kind_reg && status_reg != hpb_pkg::ST_ACCEPTED) |-> last_reg)
        else $error("rejection not marked as the final result");

    a_entry_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done_reg && kind_reg) |-> (status_reg == hpb_pkg::ST_ACCEPTED))
        else $error("flushed entry carries a status");

    a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= FILL_FULL) else $error("buffer fill beyond depth");

    a_unused_mode_answer: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && mode == hpb_pkg::MODE_UNUSED) |=> (done_reg && last_reg && !busy))
        else $error("unused mode not answered at once");

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 100ps

module testbench;

    localparam logic [1:0] EV_REFRESH   = 2'd0;
    localparam logic [1:0] EV_DELETE    = 2'd1;
    localparam logic [1:0] EV_DEL_CHILD = 2'd2;
    localparam int         NO_TYPED     = -1;
    localparam int         STALL_LIMIT  = 20000;

    typedef struct {
        logic [1:0]  mode;
        logic [30:0] src;
        logic [31:0] now;
        logic [7:0]  ev;
        logic [15:0] vol;
        logic [31:0] node;
        logic        pok;
        logic        sib;
    } hint_req_t;

    typedef struct {
        hint_req_t req;
        int        typed_status;
    } stim_row_t;

    typedef struct {
        logic        kind;
        logic [3:0]  status;
        logic [15:0] vol;
        logic [31:0] node;
        logic [1:0]  ev;
        logic [30:0] src;
        logic        last;
    } hint_res_t;

    logic        clk;
    logic        rst_n;
    logic        wr_en;
    logic        wr_index;
    logic [9:0]  wr_data;
    logic        start;
    logic        busy;
    logic [1:0]  mode;
    logic [30:0] source_id;
    logic [31:0] now_seconds;
    logic [7:0]  event_code;
    logic [15:0] volume_id;
    logic [31:0] node_id;
    logic        payload_ok;
    logic        siblings_present;
    logic        done;
    logic        kind;
    logic [3:0]  status;
    logic [15:0] out_volume_id;
    logic [31:0] out_node_id;
    logic [1:0]  out_event;
    logic [30:0] out_source_id;
    logic        last;

    hint_policer_priority_batcher dut (
        .clk(clk), .rst_n(rst_n), .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data),
        .start(start), .busy(busy), .mode(mode), .source_id(source_id),
        .now_seconds(now_seconds), .event_code(event_code), .volume_id(volume_id),
        .node_id(node_id), .payload_ok(payload_ok), .siblings_present(siblings_present),
        .done(done), .kind(kind), .status(status), .out_volume_id(out_volume_id),
        .out_node_id(out_node_id), .out_event(out_event), .out_source_id(out_source_id),
        .last(last)
    );

    logic [9:0]  hint_limit;
    logic [3:0]  reset_limit;
    logic [15:0] buf_vol  [hpb_pkg::BUFFER_DEPTH_DEF];
    logic [31:0] buf_node [hpb_pkg::BUFFER_DEPTH_DEF];
    logic [30:0] buf_src  [hpb_pkg::BUFFER_DEPTH_DEF];
    logic [1:0]  buf_ev   [hpb_pkg::BUFFER_DEPTH_DEF];
    int          buf_fill;
    logic [30:0] win_owner  [hpb_pkg::RATE_SLOTS_DEF];
    logic [31:0] win_second [hpb_pkg::RATE_SLOTS_DEF];
    logic [9:0]  win_hints  [hpb_pkg::RATE_SLOTS_DEF];
    logic [3:0]  win_resets [hpb_pkg::RATE_SLOTS_DEF];
    logic [31:0] tag_value [hpb_pkg::DEDUP_ENTRIES_DEF];
    logic [31:0] tag_second [hpb_pkg::DEDUP_ENTRIES_DEF];

    hint_res_t expected_results[$];
    stim_row_t directed_rows[$];
    int        errors;
    int        idle_cycles;

    initial clk = 1'b0;
    always #2 clk = ~clk;

    function automatic stim_row_t row(logic [1:0] m, logic [30:0] s, logic [31:0] n,
                                      logic [7:0] e, logic [15:0] v, logic [31:0] nd,
                                      logic p, logic sb, int typed);
        stim_row_t r;
        r.req = '{m, s, n, e, v, nd, p, sb};
        r.typed_status = typed;
        return r;
    endfunction

    task automatic push_status(hpb_pkg::status_t st);
        expected_results.push_back('{1'b0, st, 16'd0, 32'd0, 2'd0, 31'd0, 1'b1});
    endtask

    task automatic flush_batch();
        logic [1:0] order [4];
        order = '{hpb_pkg::EV_RESET, EV_REFRESH, EV_DELETE, EV_DEL_CHILD};
        for (int p = 0; p < 4; p++)
            for (int i = 0; i < buf_fill; i++)
                if (buf_ev[i] == order[p])
                    expected_results.push_back('{1'b1, hpb_pkg::ST_ACCEPTED, buf_vol[i],
                                                 buf_node[i], buf_ev[i], buf_src[i], 1'b0});
        buf_fill = 0;
        expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    function automatic bit dedup_hit(logic [31:0] tag, logic [31:0] now);
        int oldest;
        oldest = 0;
        for (int i = 0; i < hpb_pkg::DEDUP_ENTRIES_DEF; i++)
        begin
            if (tag_value[i] == tag && tag_second[i] == now)
                return 1'b1;
            if (tag_second[i] < tag_second[oldest])
                oldest = i;
        end
        tag_value[oldest] = tag;
        tag_second[oldest] = now;
        return 1'b0;
    endfunction

    task automatic predict_request(hint_req_t r);
        int  slot;
        bit  reset_hint;
        case (r.mode)
            hpb_pkg::MODE_FLUSH:
            begin
                if (buf_fill == 0)
                    push_status(hpb_pkg::ST_EMPTY);
                else
                    flush_batch();
                return;
            end
            hpb_pkg::MODE_FORGET:
            begin
                for (int i = 0; i < hpb_pkg::DEDUP_ENTRIES_DEF; i++)
                    if (tag_value[i] == r.node)
                    begin
                        tag_value[i] = '0;
                        tag_second[i] = '0;
                    end
                push_status(hpb_pkg::ST_FORGOTTEN);
                return;
            end
            hpb_pkg::MODE_UNUSED:
            begin
                push_status(hpb_pkg::ST_INVALID);
                return;
            end
            default: ;
        endcase
        if (!r.pok)
        begin
            push_status(hpb_pkg::ST_SHORT);
            return;
        end
        if (!r.sib)
        begin
            push_status(hpb_pkg::ST_NO_SIBS);
            return;
        end
        if (r.ev > 8'd3)
        begin
            push_status(hpb_pkg::ST_INVALID);
            return;
        end
        reset_hint = (r.ev[1:0] == hpb_pkg::EV_RESET);
        slot = r.src % hpb_pkg::RATE_SLOTS_DEF;
        if (win_owner[slot] != r.src || win_second[slot] != r.now)
        begin
            win_owner[slot] = r.src;
            win_second[slot] = r.now;
            win_hints[slot] = '0;
            win_resets[slot] = '0;
        end
        if (reset_hint)
        begin
            if (win_resets[slot] < hpb_pkg::RESET_CNT_MAX)
                win_resets[slot]++;
            if (win_resets[slot] > reset_limit)
            begin
                push_status(hpb_pkg::ST_RESET_RT);
                return;
            end
            if (dedup_hit(r.node, r.now))
            begin
                push_status(hpb_pkg::ST_DUPLICATE);
                return;
            end
        end
        else
        begin
            if (win_hints[slot] < hpb_pkg::HINT_CNT_MAX)
                win_hints[slot]++;
            if (win_hints[slot] > hint_limit)
            begin
                push_status(hpb_pkg::ST_RATE);
                return;
            end
        end
        if (buf_fill >= hpb_pkg::BUFFER_DEPTH_DEF)
        begin
            if (!reset_hint)
            begin
                push_status(hpb_pkg::ST_FULL);
                return;
            end
            buf_fill = hpb_pkg::BUFFER_DEPTH_DEF - 1;
        end
        buf_vol[buf_fill] = r.vol;
        buf_node[buf_fill] = r.node;
        buf_src[buf_fill] = r.src;
        buf_ev[buf_fill] = r.ev[1:0];
        buf_fill++;
        push_status(hpb_pkg::ST_ACCEPTED);
        if (reset_hint)
        begin
            expected_results[expected_results.size() - 1].last = 1'b0;
            flush_batch();
        end
    endtask

    task automatic send_request(hint_req_t r, int typed);
        int mark;
        start <= 1'b1;
        mode <= r.mode;
        source_id <= r.src;
        now_seconds <= r.now;
        event_code <= r.ev;
        volume_id <= r.vol;
        node_id <= r.node;
        payload_ok <= r.pok;
        siblings_present <= r.sib;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        mark = expected_results.size();
        predict_request(r);
        if (typed != NO_TYPED)
        begin
            while (expected_results.size() > mark)
                void'(expected_results.pop_back());
            push_status(hpb_pkg::status_t'(typed));
        end
    endtask

    task automatic pause(int gap);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function automatic int random_gap(bit quiet);
        int pick;
        pick = $urandom_range(0, 99);
        if (quiet || pick < 50)
            return 0;
        if (pick < 90)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic write_register(logic idx, logic [9:0] data);
        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0 || busy)
            @(posedge clk);
        repeat (50) @(posedge clk);
        wr_en <= 1'b1;
        wr_index <= idx;
        wr_data <= data;
        @(posedge clk);
        wr_en <= 1'b0;
        if (idx == hpb_pkg::REG_HINT_LIMIT)
            hint_limit = data;
        else
            reset_limit = data[3:0];
    endtask

    function automatic hint_req_t random_request(int flush_pct, logic [31:0] base_now);
        hint_req_t r;
        int pick;
        logic [30:0] pool [4];
        pool = '{31'd5, 31'd261, 31'd7, 31'h7FFFFFFF};
        pick = $urandom_range(0, 99);
        if (pick < flush_pct)
            r.mode = hpb_pkg::MODE_FLUSH;
        else if (pick < flush_pct + 4)
            r.mode = hpb_pkg::MODE_FORGET;
        else if (pick < flush_pct + 6)
            r.mode = hpb_pkg::MODE_UNUSED;
        else
            r.mode = hpb_pkg::MODE_OFFER;
        r.src = ($urandom_range(0, 7) == 0) ? 31'($urandom) : pool[$urandom_range(0, 3)];
        r.now = ($urandom_range(0, 7) == 0) ? $urandom : base_now + $urandom_range(0, 2);
        pick = $urandom_range(0, 99);
        if (pick < 5)
            r.ev = 8'($urandom_range(4, 255));
        else if (pick < 20)
            r.ev = {6'd0, hpb_pkg::EV_RESET};
        else
            r.ev = 8'($urandom_range(0, 2));
        r.vol = 16'($urandom);
        r.node = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 5));
        r.pok = ($urandom_range(0, 19) != 0);
        r.sib = ($urandom_range(0, 19) != 0);
        return r;
    endfunction

    always @(posedge clk)
    begin : result_check
        hint_res_t e;
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result kind %0d status %0d", $time, kind, status);
                errors++;
            end
            else
            begin
                e = expected_results.pop_front();
                if (kind !== e.kind || status !== e.status || out_volume_id !== e.vol ||
                    out_node_id !== e.node || out_event !== e.ev ||
                    out_source_id !== e.src || last !== e.last)
                begin
                    $display(
                        "%0t: expected kind %0d status %0d vol %h node %h ev %0d src %h last %0d",
                        $time, e.kind, e.status, e.vol, e.node, e.ev, e.src, e.last);
                    $display(
                        "%0t: actual   kind %0d status %0d vol %h node %h ev %0d src %h last %0d",
                        $time, kind, status, out_volume_id, out_node_id, out_event,
                        out_source_id, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done || wr_en)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == STALL_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        logic [9:0]  hint_settings  [7];
        logic [3:0]  reset_settings [7];
        logic [31:0] base_now;
        hint_settings  = '{10'd1000, 10'd1, 10'd1022, 10'd3, 10'd1023, 10'd0, 10'd1000};
        reset_settings = '{4'd8, 4'd1, 4'd14, 4'd2, 4'd15, 4'd0, 4'd8};
        errors = 0;
        rst_n = 1'b0;
        wr_en = 1'b0;
        wr_index = 1'b0;
        wr_data = '0;
        start = 1'b0;
        mode = '0;
        source_id = '0;
        now_seconds = '0;
        event_code = '0;
        volume_id = '0;
        node_id = '0;
        payload_ok = 1'b0;
        siblings_present = 1'b0;
        hint_limit = hpb_pkg::HINT_LIMIT_RST;
        reset_limit = hpb_pkg::RESET_LIMIT_RST;
        buf_fill = 0;
        for (int i = 0; i < hpb_pkg::RATE_SLOTS_DEF; i++)
        begin
            win_owner[i] = '0;
            win_second[i] = '0;
            win_hints[i] = '0;
            win_resets[i] = '0;
        end
        for (int i = 0; i < hpb_pkg::DEDUP_ENTRIES_DEF; i++)
        begin
            tag_value[i] = '0;
            tag_second[i] = '0;
        end

        directed_rows.push_back(row(hpb_pkg::MODE_FLUSH, 0, 0, 0, 0, 0, 1, 1,
                                    hpb_pkg::ST_EMPTY));
        directed_rows.push_back(row(hpb_pkg::MODE_UNUSED, 0, 0, 0, 0, 0, 1, 1,
                                    hpb_pkg::ST_INVALID));
        directed_rows.push_back(row(hpb_pkg::MODE_FORGET, 0, 0, 0, 0, 32'hFFFFFFFF, 1, 1,
                                    hpb_pkg::ST_FORGOTTEN));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 1, 1, 0, 1, 1, 0, 1,
                                    hpb_pkg::ST_SHORT));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 1, 1, 0, 1, 1, 0, 0,
                                    hpb_pkg::ST_SHORT));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 1, 1, 0, 1, 1, 1, 0,
                                    hpb_pkg::ST_NO_SIBS));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 1, 1, 4, 1, 1, 1, 1,
                                    hpb_pkg::ST_INVALID));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 1, 1, 255, 1, 1, 1, 1,
                                    hpb_pkg::ST_INVALID));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 31'h7FFFFFFF, 32'hFFFFFFFF, 0,
                                    16'hFFFF, 32'hFFFFFFFF, 1, 1, hpb_pkg::ST_ACCEPTED));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 0, 0, 2, 0, 0, 1, 1,
                                    hpb_pkg::ST_ACCEPTED));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 256, 0, 1, 16'h1234, 32'h89ABCDEF,
                                    1, 1, hpb_pkg::ST_ACCEPTED));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 3, 5, 0, 7, 9, 1, 1,
                                    hpb_pkg::ST_ACCEPTED));
        directed_rows.push_back(row(hpb_pkg::MODE_FLUSH, 0, 0, 0, 0, 0, 1, 1, NO_TYPED));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 9, 0, 3, 2, 0, 1, 1,
                                    hpb_pkg::ST_DUPLICATE));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 9, 0, 0, 2, 4, 1, 1, NO_TYPED));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 9, 10, 3, 2, 77, 1, 1, NO_TYPED));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 9, 10, 3, 2, 77, 1, 1, NO_TYPED));
        directed_rows.push_back(row(hpb_pkg::MODE_FORGET, 0, 0, 0, 0, 77, 1, 1,
                                    hpb_pkg::ST_FORGOTTEN));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 9, 10, 3, 2, 77, 1, 1, NO_TYPED));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 9, 10, 2, 2, 5, 1, 1, NO_TYPED));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 9, 10, 1, 2, 6, 1, 1, NO_TYPED));
        directed_rows.push_back(row(hpb_pkg::MODE_OFFER, 9, 10, 3, 2, 78, 1, 1, NO_TYPED));

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_request(directed_rows[i].req, directed_rows[i].typed_status);
            pause(i % 3);
        end

        base_now = 32'd100;
        for (int ph = 0; ph < 7; ph++)
        begin
            write_register(hpb_pkg::REG_HINT_LIMIT, hint_settings[ph]);
            write_register(hpb_pkg::REG_RESET_LIMIT, {6'd0, reset_settings[ph]});
            for (int n = 0; n < 62; n++)
            begin
                send_request(random_request(2 + ph, base_now), NO_TYPED);
                if ($urandom_range(0, 15) == 0)
                    base_now = base_now + 1;
                pause(random_gap(ph == 0));
            end
            base_now = base_now + 10;
        end

        start <= 1'b0;
        @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/hpb_pkg.sv
hdl/hint_policer_priority_batcher.sv
sim/testbench.sv
